>>> src/gbar_pkg.sv
// Package for the grid box-average restriction block.
// Holds default sizes, field widths, register indexes, state codes and the
// command and status structs shared by the controller and the datapath.
package gbar_pkg;

  localparam int FINE_DIM_DEF    = 32;
  localparam int MAX_BLOCK_DEF   = 8;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int POS_W     = 5;
  localparam int IN_SMP_W  = 24;
  localparam int AVG_W     = 24;
  localparam int COUNT_W   = 10;
  localparam int FACTOR_W  = 4;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic [FACTOR_W-1:0] BLOCK_FACTOR_RST = 4'd8;
  localparam logic [FACTOR_W-1:0] OFFSET_RST       = 4'd0;
  localparam logic [SIZE_W-1:0]   FINE_SIZE_RST    = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_FACTOR = 3'd0,
    CFG_OFFSET_X     = 3'd1,
    CFG_OFFSET_Y     = 3'd2,
    CFG_OFFSET_Z     = 3'd3,
    CFG_FINE_SIZE_X  = 3'd4,
    CFG_FINE_SIZE_Y  = 3'd5,
    CFG_FINE_SIZE_Z  = 3'd6
  } cfg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WIN   = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_DLOAD = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic wr;
    logic cap;
    logic win;
    logic scan;
    logic div_load;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

>>> src/gbar_in_if.sv
// Input channel of the grid box-average restriction block.
// Carries valid, ready and one input word; widths come from gbar_pkg.
interface gbar_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic [gbar_pkg::POS_W-1:0]           pos_x;
  logic [gbar_pkg::POS_W-1:0]           pos_y;
  logic [gbar_pkg::POS_W-1:0]           pos_z;
  logic signed [gbar_pkg::IN_SMP_W-1:0] sample;

  modport source (output valid, kind, pos_x, pos_y, pos_z, sample, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, sample, output ready);
endinterface

>>> src/gbar_out_if.sv
// Result channel of the grid box-average restriction block.
// Carries valid, ready and one result word; widths come from gbar_pkg.
interface gbar_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gbar_pkg::AVG_W-1:0] average;
  logic [gbar_pkg::COUNT_W-1:0]      cell_count;

  modport source (output valid, average, cell_count, input ready);
  modport sink   (input valid, average, cell_count, output ready);
endinterface

>>> src/gbar_ctrl.sv
// Controller of the grid box-average restriction block.
// One-hot state machine that sequences window setup, scan, division and
// result hand-off; uses the state, command and status types of gbar_pkg.
module gbar_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_kind,
  output logic            in_ready,
  input  gbar_pkg::sts_t  sts,
  output gbar_pkg::cmd_t  cmd
);

  gbar_pkg::state_t state_r, state_nxt;
  logic             take;

  assign in_ready = (state_r == gbar_pkg::S_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbar_pkg::S_IDLE: begin
        if (take && (in_kind == gbar_pkg::KIND_REQUEST)) state_nxt = gbar_pkg::S_WIN;
      end
      gbar_pkg::S_WIN: begin
        state_nxt = sts.empty ? gbar_pkg::S_DLOAD : gbar_pkg::S_SCAN;
      end
      gbar_pkg::S_SCAN: begin
        if (sts.scan_last) state_nxt = gbar_pkg::S_DRAIN;
      end
      gbar_pkg::S_DRAIN: state_nxt = gbar_pkg::S_DLOAD;
      gbar_pkg::S_DLOAD: state_nxt = gbar_pkg::S_DIV;
      gbar_pkg::S_DIV: begin
        if (sts.div_last) state_nxt = gbar_pkg::S_HOLD;
      end
      gbar_pkg::S_HOLD: begin
        if (sts.out_free) state_nxt = gbar_pkg::S_IDLE;
      end
      default: state_nxt = gbar_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbar_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.wr       = take && (in_kind == gbar_pkg::KIND_WRITE);
    cmd.cap      = take && (in_kind == gbar_pkg::KIND_REQUEST);
    cmd.win      = (state_r == gbar_pkg::S_WIN);
    cmd.scan     = (state_r == gbar_pkg::S_SCAN);
    cmd.div_load = (state_r == gbar_pkg::S_DLOAD);
    cmd.div_step = (state_r == gbar_pkg::S_DIV);
    cmd.load_out = (state_r == gbar_pkg::S_HOLD) && sts.out_free;
  end

endmodule

>>> src/gbar_dp.sv
// Datapath of the grid box-average restriction block.
// Holds the configuration registers, the fine grid memory, the window scan
// counters, the accumulator, the serial divider and the result register.
module gbar_dp #(
  parameter int FINE_DIM    = gbar_pkg::FINE_DIM_DEF,
  parameter int MAX_BLOCK   = gbar_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = gbar_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  gbar_pkg::cmd_t                        cmd,
  output gbar_pkg::sts_t                        sts,
  input  logic                                  cfg_we,
  input  logic [gbar_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gbar_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic [gbar_pkg::POS_W-1:0]            in_pos_x,
  input  logic [gbar_pkg::POS_W-1:0]            in_pos_y,
  input  logic [gbar_pkg::POS_W-1:0]            in_pos_z,
  input  logic signed [gbar_pkg::IN_SMP_W-1:0]  in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gbar_pkg::AVG_W-1:0]     out_average,
  output logic [gbar_pkg::COUNT_W-1:0]          out_cell_count
);

  localparam int AW       = $clog2(FINE_DIM);
  localparam int DEPTH    = 1 << (3 * AW);
  localparam int SUMW     = SAMPLE_BITS + gbar_pkg::COUNT_W;
  localparam int RW       = (SUMW > gbar_pkg::AVG_W) ? SUMW : gbar_pkg::AVG_W;
  localparam int DCW      = $clog2(SUMW + 1);
  localparam int MaxCells = MAX_BLOCK * MAX_BLOCK * MAX_BLOCK;
  localparam logic [gbar_pkg::FACTOR_W-1:0] MaxB = gbar_pkg::FACTOR_W'(MAX_BLOCK);
  localparam logic [6:0] DimLim = 7'(FINE_DIM);

  typedef struct packed {
    logic          empty;
    logic [AW-1:0] lo;
    logic [AW-1:0] last;
  } win_t;

  function automatic win_t axis_win(input logic [gbar_pkg::POS_W-1:0] c,
                                    input logic [gbar_pkg::FACTOR_W-1:0] b,
                                    input logic [gbar_pkg::FACTOR_W-1:0] off,
                                    input logic [gbar_pkg::SIZE_W-1:0] size);
    logic [6:0]         lim;
    logic signed [11:0] start_s;
    logic signed [11:0] stop_s;
    logic signed [11:0] lim_s;
    logic signed [11:0] lo_s;
    logic signed [11:0] hi_s;
    win_t               w;
    lim     = (7'(size) > DimLim) ? DimLim : 7'(size);
    start_s = $signed(12'(c) * 12'(b)) - $signed(12'(off));
    stop_s  = start_s + $signed(12'(b));
    lim_s   = $signed(12'(lim));
    lo_s    = (start_s < 12'sd0) ? 12'sd0 : start_s;
    hi_s    = (stop_s > lim_s) ? lim_s : stop_s;
    w.empty = (lo_s >= hi_s);
    w.lo    = AW'(lo_s);
    w.last  = AW'(hi_s - 12'sd1);
    return w;
  endfunction

  // Configuration registers.
  logic [gbar_pkg::FACTOR_W-1:0] bf_r, offx_r, offy_r, offz_r;
  logic [gbar_pkg::SIZE_W-1:0]   sizex_r, sizey_r, sizez_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bf_r    <= gbar_pkg::BLOCK_FACTOR_RST;
      offx_r  <= gbar_pkg::OFFSET_RST;
      offy_r  <= gbar_pkg::OFFSET_RST;
      offz_r  <= gbar_pkg::OFFSET_RST;
      sizex_r <= gbar_pkg::FINE_SIZE_RST;
      sizey_r <= gbar_pkg::FINE_SIZE_RST;
      sizez_r <= gbar_pkg::FINE_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gbar_pkg::CFG_BLOCK_FACTOR: bf_r    <= cfg_wdata[gbar_pkg::FACTOR_W-1:0];
        gbar_pkg::CFG_OFFSET_X:     offx_r  <= cfg_wdata[gbar_pkg::FACTOR_W-1:0];
        gbar_pkg::CFG_OFFSET_Y:     offy_r  <= cfg_wdata[gbar_pkg::FACTOR_W-1:0];
        gbar_pkg::CFG_OFFSET_Z:     offz_r  <= cfg_wdata[gbar_pkg::FACTOR_W-1:0];
        gbar_pkg::CFG_FINE_SIZE_X:  sizex_r <= cfg_wdata;
        gbar_pkg::CFG_FINE_SIZE_Y:  sizey_r <= cfg_wdata;
        gbar_pkg::CFG_FINE_SIZE_Z:  sizez_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Fine grid memory, addressed as {z, y, x}.
  logic [SAMPLE_BITS-1:0]        mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic                          rd_vld_r;
  logic                          wr_in_range;
  logic [3*AW-1:0]               wr_addr;
  logic signed [31:0]            smp_ext;
  logic [AW-1:0]                 sx_r, sy_r, sz_r;

  assign wr_in_range = (7'(in_pos_x) < DimLim) && (7'(in_pos_y) < DimLim) &&
                       (7'(in_pos_z) < DimLim);
  assign wr_addr = {AW'(7'(in_pos_z)), AW'(7'(in_pos_y)), AW'(7'(in_pos_x))};
  assign smp_ext = 32'(in_sample);

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_in_range) begin
      mem[wr_addr] <= smp_ext[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data_r <= mem[{sz_r, sy_r, sx_r}];
    end
  end

  // Request capture and window setup.
  logic [gbar_pkg::POS_W-1:0]    cx_r, cy_r, cz_r;
  logic [gbar_pkg::FACTOR_W-1:0] beff;
  win_t                          wx, wy, wz;
  logic [AW-1:0]                 xlo_r, ylo_r, zlo_r, xl_r, yl_r, zl_r;
  logic                          x_end, y_end, z_end;

  assign beff = (bf_r > MaxB) ? MaxB : bf_r;
  assign wx   = axis_win(cx_r, beff, offx_r, sizex_r);
  assign wy   = axis_win(cy_r, beff, offy_r, sizey_r);
  assign wz   = axis_win(cz_r, beff, offz_r, sizez_r);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cx_r <= in_pos_x;
      cy_r <= in_pos_y;
      cz_r <= in_pos_z;
    end
    if (cmd.win) begin
      xlo_r <= wx.lo;
      ylo_r <= wy.lo;
      zlo_r <= wz.lo;
      xl_r  <= wx.last;
      yl_r  <= wy.last;
      zl_r  <= wz.last;
    end
  end

  assign x_end = (sx_r == xl_r);
  assign y_end = (sy_r == yl_r);
  assign z_end = (sz_r == zl_r);

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      sx_r <= wx.lo;
      sy_r <= wy.lo;
      sz_r <= wz.lo;
    end else if (cmd.scan) begin
      if (!x_end) begin
        sx_r <= sx_r + AW'(1);
      end else begin
        sx_r <= xlo_r;
        if (!y_end) begin
          sy_r <= sy_r + AW'(1);
        end else begin
          sy_r <= ylo_r;
          sz_r <= sz_r + AW'(1);
        end
      end
    end
  end

  // Accumulation of the samples read back.
  logic signed [SUMW-1:0]        acc_r;
  logic [gbar_pkg::COUNT_W-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (rd_vld_r) begin
      acc_r <= acc_r + SUMW'(rd_data_r);
      cnt_r <= cnt_r + gbar_pkg::COUNT_W'(1);
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic [SUMW-1:0]              q_r;
  logic [gbar_pkg::COUNT_W:0]   rem_r;
  logic [DCW-1:0]               dcnt_r;
  logic                         neg_r;
  logic [gbar_pkg::COUNT_W:0]   rem_sh;
  logic                         rem_ge;

  assign rem_sh = {rem_r[gbar_pkg::COUNT_W-1:0], q_r[SUMW-1]};
  assign rem_ge = (rem_sh >= {1'b0, cnt_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_load) begin
      dcnt_r <= DCW'(SUMW);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_r   <= acc_r[SUMW-1] ? SUMW'(-acc_r) : SUMW'(acc_r);
      rem_r <= '0;
      neg_r <= acc_r[SUMW-1];
    end else if (cmd.div_step) begin
      q_r   <= {q_r[SUMW-2:0], rem_ge};
      rem_r <= rem_ge ? (rem_sh - {1'b0, cnt_r}) : rem_sh;
    end
  end

  // Result register.
  logic signed [SUMW-1:0]               quot;
  logic signed [RW-1:0]                 quot_w;
  logic                                 out_valid_r;
  logic signed [gbar_pkg::AVG_W-1:0]    average_r;
  logic [gbar_pkg::COUNT_W-1:0]         count_r;

  assign quot   = neg_r ? -$signed(q_r) : $signed(q_r);
  assign quot_w = RW'(quot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average_r <= (cnt_r == '0) ? '0 : quot_w[gbar_pkg::AVG_W-1:0];
      count_r   <= cnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_average    = average_r;
  assign out_cell_count = count_r;

  always_comb begin
    sts           = '0;
    sts.empty     = wx.empty || wy.empty || wz.empty;
    sts.scan_last = x_end && y_end && z_end;
    sts.div_last  = (dcnt_r == DCW'(1));
    sts.out_free  = !out_valid_r || out_ready;
  end

`ifndef ASSERT_OFF
  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (sx_r >= xlo_r && sx_r <= xl_r && sy_r >= ylo_r && sy_r <= yl_r &&
                  sz_r >= zlo_r && sz_r <= zl_r))
    else $error("scan address left the clipped window");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (32'(cnt_r) < MaxCells))
    else $error("cell count exceeds the largest window");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |=> (dcnt_r == DCW'(SUMW)))
    else $error("divider not loaded with its full step count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cnt_r == '0) |=> (out_average == '0 && out_cell_count == '0))
    else $error("empty window gave a nonzero result");
`endif

endmodule

>>> src/grid_box_average_restrict_core.sv
// Top level of the grid box-average restriction block.
// Joins the controller gbar_ctrl and the datapath gbar_dp; uses gbar_pkg and
// the channel interfaces gbar_in_if and gbar_out_if.
//
// Usage: in_if takes one word at a time. A word of kind write stores its
// sample in the fine grid (writes outside the grid are dropped) and gives no
// result. A word of kind request names a coarse cell and gives exactly one
// word on out_if: the truncated mean of the covered fine samples and their
// count, or zero and zero for an empty window. A request reads its clipped
// window with one read per cell on the single grid read port, skipping the
// scan when the window is empty, then the divider gives one quotient bit per
// cycle over SAMPLE_BITS + 10 bits before the result enters the result
// register. in_if.ready is high only while no request is at work. A finished
// result waits in the output register; while it waits the block still takes
// writes and the next request, which holds its own result until the register
// is taken. cfg_* writes one register per cycle and must be used only while
// the block is idle; the block itself does not enforce this. Synchronous
// reset restores the register defaults and empties the result register; the
// grid memory keeps its contents and an entry must be written before a
// request covers it.
module grid_box_average_restrict_core #(
  parameter int FINE_DIM    = gbar_pkg::FINE_DIM_DEF,
  parameter int MAX_BLOCK   = gbar_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = gbar_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gbar_in_if.sink                           in_if,
  gbar_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [gbar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbar_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  gbar_pkg::cmd_t cmd;
  gbar_pkg::sts_t sts;

  gbar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_kind  (in_if.kind),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbar_dp #(
    .FINE_DIM    (FINE_DIM),
    .MAX_BLOCK   (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_pos_x       (in_if.pos_x),
    .in_pos_y       (in_if.pos_y),
    .in_pos_z       (in_if.pos_z),
    .in_sample      (in_if.sample),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_average    (out_if.average),
    .out_cell_count (out_if.cell_count)
  );

endmodule

>>> bench/testbench.sv
// Self-checking bench for grid_box_average_restrict_core: fills a corner of the
// fine grid, runs directed and random words through several register settings
// and checks every result word. Needs gbar_pkg and the channel interfaces.
module testbench;

  localparam int GRID_DIM    = gbar_pkg::FINE_DIM_DEF;
  localparam int GRID_CELLS  = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int FILL_DIM    = 8;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LONG_HOLD   = 2500;
  localparam int QUIET_WAIT  = 8;
  localparam int END_WAIT    = 600;
  localparam int PHASE_WORDS = 17;
  localparam int PICK_TRIES  = 16;

  typedef struct {
    logic                                 kind;
    logic [gbar_pkg::POS_W-1:0]           x;
    logic [gbar_pkg::POS_W-1:0]           y;
    logic [gbar_pkg::POS_W-1:0]           z;
    logic signed [gbar_pkg::IN_SMP_W-1:0] smp;
  } grid_word_t;

  typedef struct {
    logic signed [gbar_pkg::AVG_W-1:0] average;
    logic [gbar_pkg::COUNT_W-1:0]      cell_count;
  } mean_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [gbar_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gbar_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gbar_in_if  in_ch();
  gbar_out_if out_ch();

  grid_box_average_restrict_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  grid_word_t                           word_q[$];
  mean_t                                mean_q[$];
  logic signed [gbar_pkg::IN_SMP_W-1:0] fine_mem [0:GRID_CELLS-1];
  bit                                   cell_planned [GRID_CELLS];
  int                                   blk_factor;
  int                                   win_ofs [3];
  int                                   win_size [3];
  int                                   errors;
  int                                   cycles;
  bit                                   calm;
  int                                   hold_tokens;
  int                                   holds_taken;
  int                                   hold_left;
  int                                   src_gap;
  int                                   sink_gap;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int eff_factor();
    return (blk_factor > gbar_pkg::MAX_BLOCK_DEF) ? gbar_pkg::MAX_BLOCK_DEF : blk_factor;
  endfunction

  function automatic int cell_index(input int x, input int y, input int z);
    return x + y * GRID_DIM + z * GRID_DIM * GRID_DIM;
  endfunction

  function automatic void axis_span(input int c, input int b, input int off, input int size,
                                    output int lo, output int hi);
    int lim;
    lim = (size > GRID_DIM) ? GRID_DIM : size;
    lo = c * b - off;
    hi = lo + b;
    if (lo < 0) lo = 0;
    if (hi > lim) hi = lim;
  endfunction

  // A random request is only sent when every cell of its window has been written.
  function automatic bit window_written(input int cx, input int cy, input int cz);
    int lo [3];
    int hi [3];
    int b;
    b = eff_factor();
    axis_span(cx, b, win_ofs[0], win_size[0], lo[0], hi[0]);
    axis_span(cy, b, win_ofs[1], win_size[1], lo[1], hi[1]);
    axis_span(cz, b, win_ofs[2], win_size[2], lo[2], hi[2]);
    for (int z = lo[2]; z < hi[2]; z++) begin
      for (int y = lo[1]; y < hi[1]; y++) begin
        for (int x = lo[0]; x < hi[0]; x++) begin
          if (!cell_planned[cell_index(x, y, z)]) return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic mean_t box_mean(input logic [gbar_pkg::POS_W-1:0] cx,
                                     input logic [gbar_pkg::POS_W-1:0] cy,
                                     input logic [gbar_pkg::POS_W-1:0] cz);
    int     lo [3];
    int     hi [3];
    int     b;
    int     n;
    longint acc;
    longint q;
    mean_t  m;
    b = eff_factor();
    axis_span(int'(cx), b, win_ofs[0], win_size[0], lo[0], hi[0]);
    axis_span(int'(cy), b, win_ofs[1], win_size[1], lo[1], hi[1]);
    axis_span(int'(cz), b, win_ofs[2], win_size[2], lo[2], hi[2]);
    acc = 0;
    n = 0;
    for (int z = lo[2]; z < hi[2]; z++) begin
      for (int y = lo[1]; y < hi[1]; y++) begin
        for (int x = lo[0]; x < hi[0]; x++) begin
          acc += fine_mem[cell_index(x, y, z)];
          n++;
        end
      end
    end
    q = (n > 0) ? acc / n : 0;
    m.average = q[gbar_pkg::AVG_W-1:0];
    m.cell_count = n[gbar_pkg::COUNT_W-1:0];
    return m;
  endfunction

  function automatic int coarse_pick(input int axis);
    int b;
    int lim;
    int top;
    b = eff_factor();
    if (b == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, GRID_DIM - 1);
    lim = (win_size[axis] > FILL_DIM) ? FILL_DIM : win_size[axis];
    top = (lim - 1 + win_ofs[axis]) / b;
    if (top > GRID_DIM - 1) top = GRID_DIM - 1;
    if (top < 0) top = 0;
    return $urandom_range(0, top);
  endfunction

  task automatic push_item(input logic kind, input int x, input int y, input int z,
                           input int smp);
    grid_word_t w;
    w.kind = kind;
    w.x = gbar_pkg::POS_W'(x);
    w.y = gbar_pkg::POS_W'(y);
    w.z = gbar_pkg::POS_W'(z);
    w.smp = gbar_pkg::IN_SMP_W'(smp);
    if (kind == gbar_pkg::KIND_WRITE) begin
      cell_planned[cell_index(int'(w.x), int'(w.y), int'(w.z))] = 1'b1;
    end
    word_q.push_back(w);
  endtask

  task automatic wait_quiet();
    while (word_q.size() != 0 || in_ch.valid || mean_q.size() != 0) @(negedge clk);
    repeat (QUIET_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input gbar_pkg::cfg_idx_t idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[gbar_pkg::CFG_DATA_W-1:0];
  endtask

  task automatic set_config(input int bf, input int ox, input int oy, input int oz,
                            input int sx, input int sy, input int sz);
    wait_quiet();
    write_reg(gbar_pkg::CFG_BLOCK_FACTOR, bf);
    write_reg(gbar_pkg::CFG_OFFSET_X, ox);
    write_reg(gbar_pkg::CFG_OFFSET_Y, oy);
    write_reg(gbar_pkg::CFG_OFFSET_Z, oz);
    write_reg(gbar_pkg::CFG_FINE_SIZE_X, sx);
    write_reg(gbar_pkg::CFG_FINE_SIZE_Y, sy);
    write_reg(gbar_pkg::CFG_FINE_SIZE_Z, sz);
    @(posedge clk);
    cfg_we <= 1'b0;
    blk_factor  = bf & 15;
    win_ofs[0]  = ox & 15;
    win_ofs[1]  = oy & 15;
    win_ofs[2]  = oz & 15;
    win_size[0] = sx & 63;
    win_size[1] = sy & 63;
    win_size[2] = sz & 63;
  endtask

  task automatic random_config();
    int bf;
    int ofs [3];
    int sz [3];
    bf = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 15);
    for (int a = 0; a < 3; a++) begin
      ofs[a] = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
      sz[a] = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 32) : $urandom_range(0, 63);
    end
    set_config(bf, ofs[0], ofs[1], ofs[2], sz[0], sz[1], sz[2]);
  endtask

  task automatic queue_random(input int n);
    int cx;
    int cy;
    int cz;
    bit found;
    for (int k = 0; k < n; k++) begin
      found = 1'b0;
      if ($urandom_range(0, 9) >= 4) begin
        for (int t = 0; t < PICK_TRIES && !found; t++) begin
          cx = coarse_pick(0);
          cy = coarse_pick(1);
          cz = coarse_pick(2);
          found = window_written(cx, cy, cz);
        end
      end
      if (found) begin
        push_item(gbar_pkg::KIND_REQUEST, cx, cy, cz, $urandom);
      end else if ($urandom_range(0, 3) != 0) begin
        push_item(gbar_pkg::KIND_WRITE, $urandom_range(0, FILL_DIM - 1),
                  $urandom_range(0, FILL_DIM - 1), $urandom_range(0, FILL_DIM - 1), $urandom);
      end else begin
        push_item(gbar_pkg::KIND_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    grid_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (word_q.size() != 0 && (calm || $urandom_range(0, 7) != 0)) begin
        nxt = word_q.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.kind   <= nxt.kind;
        in_ch.pos_x  <= nxt.x;
        in_ch.pos_y  <= nxt.y;
        in_ch.pos_z  <= nxt.z;
        in_ch.sample <= nxt.smp;
      end else begin
        if (word_q.size() != 0) src_gap = $urandom_range(0, 16);
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (holds_taken != hold_tokens) begin
      holds_taken++;
      hold_left = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 16);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mean_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (mean_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, average %0d count %0d", $time,
                   out_ch.average, out_ch.cell_count);
        end else begin
          want = mean_q.pop_front();
          if (want.average !== out_ch.average) begin
            errors++;
            $display("%0t: average expected %0d actual %0d", $time, want.average,
                     out_ch.average);
          end
          if (want.cell_count !== out_ch.cell_count) begin
            errors++;
            $display("%0t: cell_count expected %0d actual %0d", $time, want.cell_count,
                     out_ch.cell_count);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == gbar_pkg::KIND_WRITE) begin
          fine_mem[{in_ch.pos_z, in_ch.pos_y, in_ch.pos_x}] = in_ch.sample;
        end else begin
          mean_q.push_back(box_mean(in_ch.pos_x, in_ch.pos_y, in_ch.pos_z));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = gbar_pkg::CFG_BLOCK_FACTOR;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = gbar_pkg::KIND_WRITE;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    in_ch.pos_z  = '0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    errors       = 0;
    cycles       = 0;
    calm         = 1'b0;
    hold_tokens  = 0;
    holds_taken  = 0;
    hold_left    = 0;
    src_gap      = 0;
    sink_gap     = 0;
    blk_factor   = int'(gbar_pkg::BLOCK_FACTOR_RST);
    for (int a = 0; a < 3; a++) begin
      win_ofs[a]  = int'(gbar_pkg::OFFSET_RST);
      win_size[a] = int'(gbar_pkg::FINE_SIZE_RST);
    end
    for (int i = 0; i < GRID_CELLS; i++) begin
      cell_planned[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The corner cube is written first; random requests only cover written cells.
    for (int z = 0; z < FILL_DIM; z++) begin
      for (int y = 0; y < FILL_DIM; y++) begin
        for (int x = 0; x < FILL_DIM; x++) begin
          push_item(gbar_pkg::KIND_WRITE, x, y, z, $urandom);
        end
      end
    end
    push_item(gbar_pkg::KIND_WRITE, 0, 0, 0, 'h800000);
    push_item(gbar_pkg::KIND_WRITE, 31, 31, 31, 'h7FFFFF);
    push_item(gbar_pkg::KIND_WRITE, 31, 0, 0, 'hFFFFFF);
    push_item(gbar_pkg::KIND_WRITE, 0, 31, 0, 'h000000);
    push_item(gbar_pkg::KIND_WRITE, 0, 0, 31, 'h555555);
    push_item(gbar_pkg::KIND_WRITE, 10, 21, 5, 'hAAAAAA);
    push_item(gbar_pkg::KIND_REQUEST, 0, 0, 0, 'hFFFFFF);
    push_item(gbar_pkg::KIND_REQUEST, 31, 31, 31, 'h000000);
    push_item(gbar_pkg::KIND_REQUEST, 4, 0, 0, 'h000000);

    set_config(1, 0, 0, 0, 32, 32, 32);
    push_item(gbar_pkg::KIND_REQUEST, 0, 0, 0, 'h000000);
    push_item(gbar_pkg::KIND_REQUEST, 31, 31, 31, 'hFFFFFF);
    push_item(gbar_pkg::KIND_REQUEST, 31, 0, 0, 'h000000);
    push_item(gbar_pkg::KIND_REQUEST, 0, 0, 31, 'h000000);
    hold_tokens++;
    queue_random(PHASE_WORDS);

    set_config(0, 3, 0, 0, 32, 32, 32);
    push_item(gbar_pkg::KIND_REQUEST, 0, 0, 0, 'h000000);
    push_item(gbar_pkg::KIND_REQUEST, 31, 31, 31, 'h000000);
    queue_random(PHASE_WORDS);

    set_config(15, 15, 15, 15, 63, 63, 63);
    push_item(gbar_pkg::KIND_REQUEST, 0, 0, 0, 'h000000);
    push_item(gbar_pkg::KIND_REQUEST, 1, 1, 1, 'h000000);
    push_item(gbar_pkg::KIND_REQUEST, 31, 31, 31, 'h000000);
    queue_random(PHASE_WORDS);

    set_config(2, 8, 0, 3, 0, 32, 32);
    push_item(gbar_pkg::KIND_REQUEST, 0, 0, 0, 'h000000);
    push_item(gbar_pkg::KIND_REQUEST, 4, 4, 4, 'h000000);
    queue_random(PHASE_WORDS);

    set_config(8, 8, 8, 8, 1, 1, 1);
    push_item(gbar_pkg::KIND_REQUEST, 0, 0, 0, 'h000000);
    push_item(gbar_pkg::KIND_REQUEST, 1, 1, 1, 'h000000);
    queue_random(PHASE_WORDS);

    set_config(4, 1, 2, 3, 31, 17, 9);
    queue_random(PHASE_WORDS);

    for (int p = 0; p < 6; p++) begin
      random_config();
      queue_random(PHASE_WORDS);
    end

    random_config();
    calm = 1'b1;
    queue_random(PHASE_WORDS);

    wait_quiet();
    repeat (END_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
